// ===== rtl/rro_pkg.sv =====
// ----------------------------------------------------------------------------
// rro_pkg
// Shared types for the rotated rectangle overlap test pipeline.
// ----------------------------------------------------------------------------
package rro_pkg;

  localparam int NumStages = 6;

  typedef logic signed [23:0] center_t;
  typedef logic        [22:0] extent_t;
  typedef logic signed [15:0] trig_t;
  typedef logic signed [16:0] axis_t;
  typedef logic signed [39:0] term_t;
  typedef logic signed [40:0] corner_t;
  typedef logic signed [57:0] prod_t;
  typedef logic signed [58:0] proj_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

// ===== rtl/rro_corners.sv =====
// ----------------------------------------------------------------------------
// rro_corners
// Two-stage corner builder: scaled axes, then the four corners, at Q.22.
// ----------------------------------------------------------------------------
module rro_corners (
  input  logic               clk,
  input  rro_pkg::stage_en_t en,
  input  rro_pkg::center_t   cen_x,
  input  rro_pkg::center_t   cen_y,
  input  rro_pkg::extent_t   hw,
  input  rro_pkg::extent_t   hh,
  input  rro_pkg::trig_t     cs,
  input  rro_pkg::trig_t     sn,
  output rro_pkg::corner_t   x [4],
  output rro_pkg::corner_t   y [4]
);
  import rro_pkg::*;

  corner_t cx;
  corner_t cy;
  term_t   ux;
  term_t   uy;
  term_t   vx;
  term_t   vy;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      cx <= {{3{cen_x[23]}}, cen_x, 14'b0};
      cy <= {{3{cen_y[23]}}, cen_y, 14'b0};
      ux <= term_t'($signed({1'b0, hw})) * term_t'(cs);
      uy <= term_t'($signed({1'b0, hw})) * term_t'(sn);
      vx <= -(term_t'($signed({1'b0, hh})) * term_t'(sn));
      vy <= term_t'($signed({1'b0, hh})) * term_t'(cs);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int k = 0; k < 4; k++) begin
        x[k] <= cx + (k[0] ? -{ux[39], ux} : {ux[39], ux})
                   + (k[1] ? -{vx[39], vx} : {vx[39], vx});
        y[k] <= cy + (k[0] ? -{uy[39], uy} : {uy[39], uy})
                   + (k[1] ? -{vy[39], vy} : {vy[39], vy});
      end
    end
  end

endmodule

// ===== rtl/rotated_rect_overlap_test_unit.sv =====
// ----------------------------------------------------------------------------
// rotated_rect_overlap_test_unit
// Separating axis overlap test for two oriented rectangles.
// ----------------------------------------------------------------------------
// Input channel: one beat carries both rectangles (center, half extents,
// cosine and sine). Output channel: one beat with overlap, 1 when no
// separating axis exists; touching projections count as overlap.
// Six register stages: scaled axes, corners, corner-by-axis products,
// projections, per-axis min/max, final compare. One pair enters every
// cycle unless a stall on the output has filled the pipeline. Each stage
// holds its beat while the next stage is full and stalled, so a stall on
// the output fills bubbles first and then stops the input; nothing is
// dropped or repeated. Reset clears all stage valid bits; data registers
// are not reset. No state carries from one pair to the next.
// ----------------------------------------------------------------------------
module rotated_rect_overlap_test_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rro_pkg::center_t a_center_x,
  input  rro_pkg::center_t a_center_y,
  input  rro_pkg::extent_t a_half_width,
  input  rro_pkg::extent_t a_half_height,
  input  rro_pkg::trig_t   a_cosine,
  input  rro_pkg::trig_t   a_sine,
  input  rro_pkg::center_t b_center_x,
  input  rro_pkg::center_t b_center_y,
  input  rro_pkg::extent_t b_half_width,
  input  rro_pkg::extent_t b_half_height,
  input  rro_pkg::trig_t   b_cosine,
  input  rro_pkg::trig_t   b_sine,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             overlap
);
  import rro_pkg::*;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;
  stage_en_t            cen;

  axis_t   px1 [4];
  axis_t   py1 [4];
  axis_t   px2 [4];
  axis_t   py2 [4];
  corner_t ax [4];
  corner_t ay [4];
  corner_t bx [4];
  corner_t by [4];
  prod_t   mx [2][4][4];
  prod_t   my [2][4][4];
  proj_t   pj [2][4][4];
  proj_t   lo [2][4];
  proj_t   hi [2][4];
  proj_t   lo_next [2][4];
  proj_t   hi_next [2][4];
  logic    sep_next;

  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
    cen.s1 = en[0];
    cen.s2 = en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  rro_corners u_corners_a (
    .clk   (clk),
    .en    (cen),
    .cen_x (a_center_x),
    .cen_y (a_center_y),
    .hw    (a_half_width),
    .hh    (a_half_height),
    .cs    (a_cosine),
    .sn    (a_sine),
    .x     (ax),
    .y     (ay)
  );

  rro_corners u_corners_b (
    .clk   (clk),
    .en    (cen),
    .cen_x (b_center_x),
    .cen_y (b_center_y),
    .hw    (b_half_width),
    .hh    (b_half_height),
    .cs    (b_cosine),
    .sn    (b_sine),
    .x     (bx),
    .y     (by)
  );

  // axes: uA, vA, uB, vB
  always_ff @(posedge clk) begin
    if (en[0]) begin
      px1[0] <= {a_cosine[15], a_cosine};
      py1[0] <= {a_sine[15], a_sine};
      px1[1] <= -{a_sine[15], a_sine};
      py1[1] <= {a_cosine[15], a_cosine};
      px1[2] <= {b_cosine[15], b_cosine};
      py1[2] <= {b_sine[15], b_sine};
      px1[3] <= -{b_sine[15], b_sine};
      py1[3] <= {b_cosine[15], b_cosine};
    end
    if (en[1]) begin
      px2 <= px1;
      py2 <= py1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          mx[0][j][k] <= prod_t'(ax[k]) * prod_t'(px2[j]);
          my[0][j][k] <= prod_t'(ay[k]) * prod_t'(py2[j]);
          mx[1][j][k] <= prod_t'(bx[k]) * prod_t'(px2[j]);
          my[1][j][k] <= prod_t'(by[k]) * prod_t'(py2[j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 2; r++) begin
        for (int j = 0; j < 4; j++) begin
          for (int k = 0; k < 4; k++) begin
            pj[r][j][k] <= {mx[r][j][k][57], mx[r][j][k]}
                         + {my[r][j][k][57], my[r][j][k]};
          end
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 4; j++) begin
        lo_next[r][j] = pj[r][j][0];
        hi_next[r][j] = pj[r][j][0];
        for (int k = 1; k < 4; k++) begin
          if (pj[r][j][k] < lo_next[r][j]) begin
            lo_next[r][j] = pj[r][j][k];
          end
          if (pj[r][j][k] > hi_next[r][j]) begin
            hi_next[r][j] = pj[r][j][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  always_comb begin
    sep_next = 1'b0;
    for (int j = 0; j < 4; j++) begin
      if (hi[0][j] < lo[1][j] || hi[1][j] < lo[0][j]) begin
        sep_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      overlap <= !sep_next;
    end
  end

endmodule
